// ----- hw/rtl/dq_pkg.sv -----
package dq_pkg;

	// request kinds
	localparam logic [2:0] REQ_PUSH_FRONT = 3'd0;
	localparam logic [2:0] REQ_PUSH_BACK  = 3'd1;
	localparam logic [2:0] REQ_POP_FRONT  = 3'd2;
	localparam logic [2:0] REQ_POP_BACK   = 3'd3;
	localparam logic [2:0] REQ_PEEK_FRONT = 3'd4;
	localparam logic [2:0] REQ_PEEK_BACK  = 3'd5;

	// result status
	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_EMPTY = 2'd1;
	localparam logic [1:0] ST_FULL  = 2'd2;

	// per-cell moves
	localparam logic [2:0] CELL_HOLD   = 3'd0;
	localparam logic [2:0] CELL_PUSH_F = 3'd1;
	localparam logic [2:0] CELL_PUSH_B = 3'd2;
	localparam logic [2:0] CELL_POP_F  = 3'd3;
	localparam logic [2:0] CELL_POP_B  = 3'd4;

	typedef struct packed {
		logic [2:0]         req_type;
		logic signed [31:0] push_value;
	} req_t;

	typedef struct packed {
		logic signed [31:0] read_value;
		logic [1:0]         status;
		logic               is_empty;
		logic [4:0]         occupancy;
	} rsp_t;

	typedef struct packed {
		logic [2:0] op;
	} cell_ctrl_t;

endpackage

// ----- hw/rtl/double_ended_queue.sv -----
// Bounded deque built as a row of shift cells; the front element always sits in cell 0.
// A request's result is registered and shows in the cycle after acceptance.
// Throughput: one request per cycle unless a held result stalls it (rsp_ready low); cells move only on pushes and pops.
// The back element is found through a one-hot tail token, OR-ed down the cell row.
// Reset (arst_n low, asynchronous) empties the deque and clears the result valid flag;
// cell data is not reset and is only ever read after being written.
module double_ended_queue import dq_pkg::*; #(
	parameter int DEPTH      = 16,
	parameter int DATA_WIDTH = 32
) (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_ready,
	input  req_t req,
	output logic rsp_valid,
	input  logic rsp_ready,
	output rsp_t rsp
);

	localparam int CW = $clog2(DEPTH + 1);
	localparam int DW = DATA_WIDTH;

	// element count and derived flags
	logic [CW-1:0] count_q;
	logic [CW-1:0] count_d;
	logic          empty;
	logic          full;

	// cell row wiring
	logic [DW-1:0] cell_data [DEPTH];
	logic [DW-1:0] cell_or   [DEPTH];
	logic [DEPTH-1:0] tail_vec;
	logic [DW-1:0] word;
	logic [DW-1:0] back_word;
	cell_ctrl_t    cell_ctrl;

	// request decode
	logic          in_fire;
	logic [2:0]    op;
	logic [1:0]    st;
	logic [DW-1:0] rd;

	// result register
	logic rsp_valid_q;
	rsp_t rsp_q;

	logic [DW+31:0] word_ext;
	logic [DW+31:0] rd_ext;
	logic [CW+4:0]  cnt_ext;

	assign in_fire   = req_valid && req_ready;
	assign req_ready = !rsp_valid_q || rsp_ready;

	assign empty = (count_q == '0);
	assign full  = (count_q == CW'(DEPTH));

	// keep the low DATA_WIDTH bits of the incoming word
	assign word_ext = {{DW{1'b0}}, req.push_value};
	assign word     = word_ext[DW-1:0];

	// the OR chain ends at the last cell; only the tail cell contributes
	assign back_word = cell_or[DEPTH-1];

	always_comb begin
		op      = CELL_HOLD;
		st      = ST_OK;
		rd      = '0;
		count_d = count_q;
		case (req.req_type)
			REQ_PUSH_FRONT: begin
				if (full) begin
					st = ST_FULL;
				end else begin
					op      = CELL_PUSH_F;
					count_d = count_q + CW'(1);
				end
			end
			REQ_PUSH_BACK: begin
				if (full) begin
					st = ST_FULL;
				end else begin
					op      = CELL_PUSH_B;
					count_d = count_q + CW'(1);
				end
			end
			REQ_POP_FRONT: begin
				if (empty) begin
					st = ST_EMPTY;
				end else begin
					op      = CELL_POP_F;
					rd      = cell_data[0];
					count_d = count_q - CW'(1);
				end
			end
			REQ_POP_BACK: begin
				if (empty) begin
					st = ST_EMPTY;
				end else begin
					op      = CELL_POP_B;
					rd      = back_word;
					count_d = count_q - CW'(1);
				end
			end
			REQ_PEEK_FRONT: begin
				if (empty) begin
					st = ST_EMPTY;
				end else begin
					rd = cell_data[0];
				end
			end
			REQ_PEEK_BACK: begin
				if (empty) begin
					st = ST_EMPTY;
				end else begin
					rd = back_word;
				end
			end
			// unused kinds: no state change, status ok
			default: begin
				op = CELL_HOLD;
			end
		endcase
	end

	// cells move only on an accepted request
	assign cell_ctrl.op = in_fire ? op : CELL_HOLD;

	genvar gi;
	generate
		for (gi = 0; gi < DEPTH; gi++) begin : g_cell
			logic [DW-1:0] l_data;
			logic [DW-1:0] r_data;
			logic          l_tail;
			logic          r_tail;
			logic [DW-1:0] o_in;

			if (gi == 0) begin : g_head
				// cell 0 takes the pushed word on a front push; on a back push into
				// an empty deque it acts as the slot after the tail
				assign l_data = word;
				assign l_tail = empty;
				assign o_in   = '0;
			end else begin : g_body
				assign l_data = cell_data[gi-1];
				assign l_tail = tail_vec[gi-1];
				assign o_in   = cell_or[gi-1];
			end

			if (gi == DEPTH - 1) begin : g_end
				assign r_data = '0;
				assign r_tail = 1'b0;
			end else begin : g_mid
				assign r_data = cell_data[gi+1];
				assign r_tail = tail_vec[gi+1];
			end

			dq_cell #(
				.DW(DW)
			) u_cell (
				.clk       (clk),
				.arst_n    (arst_n),
				.ctrl      (cell_ctrl),
				.word      (word),
				.left_data (l_data),
				.right_data(r_data),
				.left_tail (l_tail),
				.right_tail(r_tail),
				.or_in     (o_in),
				.data      (cell_data[gi]),
				.tail      (tail_vec[gi]),
				.or_out    (cell_or[gi])
			);
		end
	endgenerate

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (in_fire) begin
			count_q <= count_d;
		end
	end

	// result formatting: read word keeps its low 32 bits, occupancy keeps its low five bits
	assign rd_ext  = {32'b0, rd};
	assign cnt_ext = {5'b0, count_d};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (in_fire) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			rsp_q.read_value <= rd_ext[31:0];
			rsp_q.status     <= st;
			rsp_q.is_empty   <= (count_d == '0);
			rsp_q.occupancy  <= cnt_ext[4:0];
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

`ifndef NO_ASSERTIONS
	// at most one tail cell at any time
	a_tail_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(tail_vec))
		else $error("tail token not one-hot");

	// a tail exists exactly when the deque holds elements
	a_tail_count: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q == '0) == (tail_vec == '0))
		else $error("tail token disagrees with count");

	// an accepted request always yields a result next cycle
	a_rsp_follows: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire |=> rsp_valid_q)
		else $error("missing result after request");

	// a full error leaves the count at its ceiling
	a_full_status: assert property (@(posedge clk) disable iff (!arst_n)
		(in_fire && st == ST_FULL) |=> (count_q == CW'(DEPTH)))
		else $error("full status with room left");
`endif

endmodule

// ----- hw/rtl/dq_cell.sv -----
module dq_cell import dq_pkg::*; #(
	parameter int DW = 32
) (
	input  logic          clk,
	input  logic          arst_n,
	input  cell_ctrl_t    ctrl,
	input  logic [DW-1:0] word,
	input  logic [DW-1:0] left_data,
	input  logic [DW-1:0] right_data,
	input  logic          left_tail,
	input  logic          right_tail,
	input  logic [DW-1:0] or_in,
	output logic [DW-1:0] data,
	output logic          tail,
	output logic [DW-1:0] or_out
);

	logic [DW-1:0] data_q;
	logic          tail_q;

	// payload, no reset
	always_ff @(posedge clk) begin
		case (ctrl.op)
			CELL_PUSH_F: data_q <= left_data;
			CELL_PUSH_B: begin
				if (left_tail) begin
					data_q <= word;
				end
			end
			CELL_POP_F: data_q <= right_data;
			default: data_q <= data_q;
		endcase
	end

	// tail token: moves right on a push, left on a pop
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tail_q <= 1'b0;
		end else begin
			case (ctrl.op)
				CELL_PUSH_F, CELL_PUSH_B: tail_q <= left_tail;
				CELL_POP_F, CELL_POP_B:   tail_q <= right_tail;
				default: tail_q <= tail_q;
			endcase
		end
	end

	assign data   = data_q;
	assign tail   = tail_q;
	assign or_out = or_in | (tail_q ? data_q : '0);

endmodule
